/* rtl/dfr_pkg.sv */
`timescale 1ns / 1ps
// dfr_pkg: payload types, des round tables (e expansion, p permutation, s-boxes)
// and the bit-shuffling helpers built on them. no dependencies.
package dfr_pkg;

   localparam int unsigned HalfWidth   = 32;
   localparam int unsigned SubkeyWidth = 48;
   localparam int unsigned NumSbox     = 8;

   typedef logic [HalfWidth-1:0]   half_type;
   typedef logic [SubkeyWidth-1:0] subkey_type;
   typedef logic [5:0]  six_type;
   typedef logic [3:0]  nibble_type;

   // des tables count bit 1 as the msb of the word they act on
   localparam logic [5:0] EXP_TAB [0:47] = '{
      6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd4,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9,
      6'd8,  6'd9,  6'd10, 6'd11, 6'd12, 6'd13, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
      6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
      6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
   };

   localparam logic [5:0] PERM_TAB [0:31] = '{
      6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
      6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
      6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
      6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
   };

   // each s-box is 64 nibbles, entry 0 in the top nibble, index = {row, col}
   localparam logic [255:0] SBOX_TAB [0:7] = '{
      256'hE4D12FB83A6C5907_0F74E2D1A6CB9538_41E8D62BFC973A50_FC8249175B3EA06D,
      256'hF18E6B34972DC05A_3D47F28EC01A69B5_0E7BA4D158C6932F_D8A13F42B67C05E9,
      256'hA09E63F51DC7B428_D709346A285ECBF1_D6498F30B12C5AE7_1AD069874FE3B52C,
      256'h7DE3069A1285BC4F_D8B56F03472C1AE9_A690CB7DF13E5284_3F06A1D8945BC72E,
      256'h2C417AB6853FD0E9_EB2C47D150FA3986_421BAD78F9C5630E_B8C71E2D6F09A453,
      256'hC1AF92680D34E75B_AF427C9561DE0B38_9EF528C3704A1DB6_432C95FABE17608D,
      256'h4B2EF08D3C975A61_D0B7491AE35C2F86_14BDC37EAF680592_6BD814A7950FE23C,
      256'hD2846FB1A93E50C7_1FD8A374C56B0E92_7B419CE206ADF358_21E74A8DFC90356B
   };

   function automatic subkey_type expand_half(input half_type r);
      subkey_type e;
      logic [5:0] pos;
      e = '0;
      for (int i = 0; i < 48; i++) begin
         pos = 6'd32 - EXP_TAB[i];
         e[47 - i] = r[pos[4:0]];
      end
      return e;
   endfunction

   function automatic half_type permute_p(input half_type w);
      half_type p;
      logic [5:0] pos;
      p = '0;
      for (int i = 0; i < 32; i++) begin
         pos = 6'd32 - PERM_TAB[i];
         p[31 - i] = w[pos[4:0]];
      end
      return p;
   endfunction

   // outer bits pick the row, middle four the column
   function automatic nibble_type sbox_lookup(input logic [2:0] box, input six_type six);
      six_type idx;
      six_type nib;
      idx = {six[5], six[0], six[4:1]};
      nib = 6'd63 - idx;
      return SBOX_TAB[box][{nib, 2'b00} +: 4];
   endfunction

endpackage

/* rtl/dfr_if.sv */
`timescale 1ns / 1ps
// dfr_req_if / dfr_rsp_if: valid-ready channels for round inputs and results
// depends on dfr_pkg for the payload types
interface dfr_req_if;
   logic                  valid;
   logic                  ready;
   dfr_pkg::half_type     left_half;
   dfr_pkg::half_type     right_half;
   dfr_pkg::subkey_type   round_subkey;

   modport source (output valid, output left_half, output right_half,
                   output round_subkey, input ready);
   modport sink   (input valid, input left_half, input right_half,
                   input round_subkey, output ready);
endinterface

interface dfr_rsp_if;
   logic                  valid;
   logic                  ready;
   dfr_pkg::half_type     new_left;
   dfr_pkg::half_type     new_right;

   modport source (output valid, output new_left, output new_right, input ready);
   modport sink   (input valid, input new_left, input new_right, output ready);
endinterface

/* rtl/dfr_round_f.sv */
`timescale 1ns / 1ps
// dfr_round_f: combinational des f function plus the left-half xor
// depends on dfr_pkg tables and helpers
module dfr_round_f (
   input  dfr_pkg::half_type   left_half,
   input  dfr_pkg::half_type   right_half,
   input  dfr_pkg::subkey_type round_subkey,
   output dfr_pkg::half_type   new_left
);
   import dfr_pkg::*;

   subkey_type mixed;
   half_type   sbox_out;

   assign mixed = expand_half(right_half) ^ round_subkey;

   // group 0 is the top six bits and feeds s1
   always_comb begin
      sbox_out = '0;
      for (int g = 0; g < NumSbox; g++) begin
         sbox_out[31 - 4*g -: 4] = sbox_lookup(3'(g), mixed[47 - 6*g -: 6]);
      end
   end

   assign new_left = left_half ^ permute_p(sbox_out);

endmodule

/* rtl/des_feistel_round_core.sv */
`timescale 1ns / 1ps
// des_feistel_round_core: one des round (no half swap) between an input
// register and a result register; depends on dfr_pkg, dfr_if, dfr_round_f
//
//   channel    dir   payload                                    handshake
//   req_chan   in    left_half, right_half, round_subkey        valid/ready
//   rsp_chan   out   new_left, new_right                        valid/ready
//
// one beat in and one beat out per cycle, sustained while rsp_chan is ready
// data path: input register, then f logic into the result register
// a stall on rsp_chan holds the result register; the input register still
// takes a beat while empty, and ready backs off only when both stages are full
// reset empties both stages; payload registers are not reset
module des_feistel_round_core (
   input  logic         clock,
   input  logic         reset,
   dfr_req_if.sink      req_chan,
   dfr_rsp_if.source    rsp_chan
);
   import dfr_pkg::*;

   // input stage
   logic        s1_valid_ff, s1_valid_in;
   half_type    s1_left_ff,  s1_right_ff;
   subkey_type  s1_key_ff;

   // result stage
   logic        rsp_valid_ff, rsp_valid_in;
   half_type    rsp_left_ff, rsp_right_ff;

   half_type    f_left;
   logic        rsp_free;   // result register can take a beat
   logic        s1_move;    // input stage hands its beat on
   logic        req_take;   // beat accepted on req_chan

   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;
   assign s1_move  = s1_valid_ff && rsp_free;
   assign req_chan.ready = !s1_valid_ff || rsp_free;
   assign req_take = req_chan.valid && req_chan.ready;

   assign s1_valid_in  = req_take || (s1_valid_ff && !rsp_free);
   assign rsp_valid_in = s1_move || (rsp_valid_ff && !rsp_chan.ready);

   dfr_round_f u_round_f (
      .left_half    (s1_left_ff),
      .right_half   (s1_right_ff),
      .round_subkey (s1_key_ff),
      .new_left     (f_left)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload capture, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_left_ff  <= req_chan.left_half;
         s1_right_ff <= req_chan.right_half;
         s1_key_ff   <= req_chan.round_subkey;
      end
      if (s1_move) begin
         rsp_left_ff  <= f_left;
         rsp_right_ff <= s1_right_ff;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.new_left  = rsp_left_ff;
   assign rsp_chan.new_right = rsp_right_ff;

`ifndef SYNTHESIS
   // a beat leaving the input stage always lands in the result register
   a_move_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      s1_move |=> rsp_valid_ff)
      else $error("input stage beat lost on its way to the result register");

   // right half reaches the result unchanged
   a_right_passes: assert property (@(posedge clock) disable iff (reset)
      s1_move |=> (rsp_chan.new_right == $past(s1_right_ff)))
      else $error("right half altered between stages");

   // an accepted beat always occupies the input stage next cycle
   a_take_fills_s1: assert property (@(posedge clock) disable iff (reset)
      req_take |=> s1_valid_ff)
      else $error("accepted beat not held in the input stage");

   // input stage full and result stalled means no new beat is taken
   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && !rsp_chan.ready) |-> !req_chan.ready)
      else $error("ready raised while both stages are full");
`endif

endmodule
